// ----- hdl/mptc_pkg.sv -----
// Package for the mouse packet to text cursor block: payload structs, register indexes,
// reset constants and the front-to-back command type. No dependencies.
`default_nettype none
package mptc_pkg;

  typedef enum logic [0:0] {
    OP_DATA = 1'b0,
    OP_POLL = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_FOUR_BYTE  = 3'd0,
    REG_X_DIV      = 3'd1,
    REG_Y_DIV      = 3'd2,
    REG_MAX_STEP   = 3'd3,
    REG_FREEZE_LEN = 3'd4,
    REG_COL_LIMIT  = 3'd5,
    REG_ROW_LIMIT  = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic              has_update;
    logic [7:0]        cursor_column;
    logic [7:0]        cursor_row;
    logic signed [15:0] wheel_total;
  } out_item_t;

  // Command handed from the packet assembler to the cursor engine.
  typedef struct packed {
    logic       poll;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] wheel;
  } cmd_t;

  typedef struct packed {
    logic       four_byte;
    logic [7:0] x_div;
    logic [7:0] y_div;
    logic [3:0] max_step;
    logic [3:0] freeze_len;
    logic [7:0] col_limit;
    logic [7:0] row_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DIV_X,
    ST_DIV_Y,
    ST_MOVE
  } eng_state_e;

  localparam logic [7:0] ColReset = 8'd40;
  localparam logic [7:0] RowReset = 8'd12;
  localparam logic [7:0] SyncMask = 8'h08;

endpackage
`default_nettype wire

// ----- hdl/mouse_packet_to_text_cursor_top.sv -----
// Top level of the mouse packet to text cursor block.
// Depends on mptc_pkg, mptc_front, mptc_queue, mptc_back, mptc_div.
`default_nettype none
// PS/2 mouse packet decoder driving a text cursor. The front end takes one
// transaction per cycle (data byte or poll), filters sync, assembles 3- or
// 4-byte packets and pushes a command into a two-entry queue; it only stalls
// when that queue is full. The back end runs each motion packet through the
// dequeue state, an accumulate state, then the shared one-bit-per-cycle
// divider for x and again for y, then the cursor move. Wheel packets and
// polls are handled in the dequeue state alone. A poll with news yields one
// output transaction held in a register until it is taken.
module mouse_packet_to_text_cursor_top #(
  parameter int unsigned ACCUM_WIDTH = 16
) (
  input  wire                 logic clk_i,
  input  wire                 logic rst_ni,
  input  mptc_pkg::in_item_t  in_i,
  input  wire                 logic in_valid_i,
  output logic                in_stall_o,
  output mptc_pkg::out_item_t out_o,
  output logic                out_valid_o,
  input  wire                 logic out_stall_i,
  input  wire                 logic cfg_we_i,
  input  wire                 logic [2:0] cfg_idx_i,
  input  wire                 logic [7:0] cfg_data_i
);
  mptc_pkg::cfg_t cfg_q;
  mptc_pkg::cmd_t push_cmd, pop_cmd;
  logic push, full, empty, pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.four_byte  <= 1'b0;
      cfg_q.x_div      <= 8'd10;
      cfg_q.y_div      <= 8'd20;
      cfg_q.max_step   <= 4'd2;
      cfg_q.freeze_len <= 4'd3;
      cfg_q.col_limit  <= 8'd79;
      cfg_q.row_limit  <= 8'd24;
    end else if (cfg_we_i) begin
      case (mptc_pkg::reg_e'(cfg_idx_i))
        mptc_pkg::REG_FOUR_BYTE:  cfg_q.four_byte  <= cfg_data_i[0];
        mptc_pkg::REG_X_DIV:      cfg_q.x_div      <= cfg_data_i;
        mptc_pkg::REG_Y_DIV:      cfg_q.y_div      <= cfg_data_i;
        mptc_pkg::REG_MAX_STEP:   cfg_q.max_step   <= cfg_data_i[3:0];
        mptc_pkg::REG_FREEZE_LEN: cfg_q.freeze_len <= cfg_data_i[3:0];
        mptc_pkg::REG_COL_LIMIT:  cfg_q.col_limit  <= cfg_data_i;
        mptc_pkg::REG_ROW_LIMIT:  cfg_q.row_limit  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mptc_front u_front (
    .clk_i, .rst_ni, .four_byte_i(cfg_q.four_byte), .in_i, .in_valid_i,
    .in_stall_o, .cmd_o(push_cmd), .cmd_valid_o(push), .cmd_full_i(full)
  );

  mptc_queue u_queue (
    .clk_i, .rst_ni, .wr_data_i(push_cmd), .wr_en_i(push), .full_o(full),
    .rd_data_o(pop_cmd), .empty_o(empty), .rd_en_i(pop)
  );

  mptc_back #(.ACCUM_WIDTH(ACCUM_WIDTH)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .cmd_i(pop_cmd), .cmd_empty_i(empty),
    .cmd_pop_o(pop), .out_o, .out_valid_o, .out_stall_i
  );
endmodule
`default_nettype wire

// ----- hdl/mptc_front.sv -----
// Packet assembler: sync filtering and byte collection into commands.
// Depends on mptc_pkg.
`default_nettype none
module mptc_front (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic four_byte_i,
  input  mptc_pkg::in_item_t in_i,
  input  wire                logic in_valid_i,
  output logic               in_stall_o,
  output mptc_pkg::cmd_t     cmd_o,
  output logic               cmd_valid_o,
  input  wire                logic cmd_full_i
);
  logic [1:0] pos_q, pos_d;
  logic [7:0] b1_q, b2_q;
  logic       acc;
  logic [2:0] cnt;
  logic       done;

  assign in_stall_o = cmd_full_i;
  assign acc = in_valid_i && !cmd_full_i;
  assign cnt = {1'b0, pos_q} + 3'd1;
  assign done = (cnt >= (four_byte_i ? 3'd4 : 3'd3));

  always_comb begin
    pos_d       = pos_q;
    cmd_valid_o = 1'b0;
    cmd_o.poll  = 1'b0;
    cmd_o.dx    = b1_q;
    cmd_o.dy    = (pos_q == 2'd2) ? in_i.data_byte : b2_q;
    cmd_o.wheel = four_byte_i ? in_i.data_byte : 8'd0;
    if (acc) begin
      if (in_i.operation == mptc_pkg::OP_POLL) begin
        cmd_o.poll  = 1'b1;
        cmd_valid_o = 1'b1;
      end else if (pos_q != 2'd0 || (in_i.data_byte & mptc_pkg::SyncMask) != 8'd0) begin
        if (done) begin
          pos_d       = 2'd0;
          cmd_valid_o = 1'b1;
        end else begin
          pos_d = cnt[1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // packet bytes: no reset
  always_ff @(posedge clk_i) begin
    if (acc && in_i.operation == mptc_pkg::OP_DATA) begin
      if (pos_q == 2'd1) b1_q <= in_i.data_byte;
      if (pos_q == 2'd2) b2_q <= in_i.data_byte;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/mptc_queue.sv -----
// Two-entry command queue between assembler and engine.
// Depends on mptc_pkg.
`default_nettype none
module mptc_queue (
  input  wire            logic clk_i,
  input  wire            logic rst_ni,
  input  mptc_pkg::cmd_t wr_data_i,
  input  wire            logic wr_en_i,
  output logic           full_o,
  output mptc_pkg::cmd_t rd_data_o,
  output logic           empty_o,
  input  wire            logic rd_en_i
);
  mptc_pkg::cmd_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en_i) wp_q <= ~wp_q;
      if (rd_en_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_en_i} - {1'b0, rd_en_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

// ----- hdl/mptc_div.sv -----
// Iterative restoring divider: unsigned magnitude by 8-bit divisor, one bit a cycle.
// No dependencies.
`default_nettype none
module mptc_div #(
  parameter int unsigned W = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [7:0]   divisor_i,
  output logic              busy_o,
  output logic [W-1:0]      quot_o
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0]  q_q;
  logic [8:0]    r_q;
  logic [CW-1:0] n_q;
  logic [8:0]    trial;

  assign busy_o = (n_q != '0);
  assign quot_o = q_q;
  assign trial  = {r_q[7:0], q_q[W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (start_i) begin
      n_q <= CW'(W);
    end else if (busy_o) begin
      n_q <= n_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
    end else if (busy_o) begin
      if (trial >= {1'b0, divisor_i}) begin
        r_q <= trial - {1'b0, divisor_i};
        q_q <= {q_q[W-2:0], 1'b1};
      end else begin
        r_q <= trial;
        q_q <= {q_q[W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/mptc_back.sv -----
// Cursor engine: accumulators, divide, clamp, cursor position and poll results.
// Depends on mptc_pkg and mptc_div.
`default_nettype none
module mptc_back #(
  parameter int unsigned ACCUM_WIDTH = 16
) (
  input  wire                 logic clk_i,
  input  wire                 logic rst_ni,
  input  mptc_pkg::cfg_t      cfg_i,
  input  mptc_pkg::cmd_t      cmd_i,
  input  wire                 logic cmd_empty_i,
  output logic                cmd_pop_o,
  output mptc_pkg::out_item_t out_o,
  output logic                out_valid_o,
  input  wire                 logic out_stall_i
);
  localparam int unsigned AW = ACCUM_WIDTH;
  localparam logic signed [AW:0] AMax = (AW+1)'((64'd1 << (AW - 1)) - 64'd1);
  localparam logic signed [AW:0] AMin = -AMax - (AW+1)'(1);

  mptc_pkg::eng_state_e st_q, st_d;
  logic signed [AW-1:0] ax_q, ay_q;
  logic [3:0]  frz_q;
  logic [7:0]  col_q, row_q;
  logic        chg_q;
  logic signed [15:0] wsum_q;
  logic [7:0]  dx_q, dy_q;
  logic signed [4:0] mx_q, my_q;
  logic        ovalid_q;
  mptc_pkg::out_item_t out_q;

  logic        div_start, div_busy;
  logic [AW-1:0] div_in, div_q;
  logic [7:0]  div_d;
  logic        cur_y;
  logic signed [AW-1:0] cur_a;

  assign out_o       = out_q;
  assign out_valid_o = ovalid_q;

  assign cur_y = (st_q == mptc_pkg::ST_DIV_Y);
  assign cur_a = cur_y ? ay_q : ax_q;
  assign div_d = cur_y ? cfg_i.y_div : cfg_i.x_div;
  assign div_in = cur_a[AW-1] ? AW'(-cur_a) : cur_a;

  logic div_go_q;
  assign div_start = div_go_q;

  mptc_div #(.W(AW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_in),
    .divisor_i(div_d), .busy_o(div_busy), .quot_o(div_q)
  );

  // clamp quotient magnitude to max_step, restore sign
  logic [AW-1:0] qmag;
  logic signed [4:0] qs;
  logic signed [AW+8:0] prod;
  assign qmag = (div_q > AW'(cfg_i.max_step)) ? AW'(cfg_i.max_step) : div_q;
  assign qs = (div_d == 8'd0) ? 5'sd0 :
              (cur_a[AW-1] ? -$signed({1'b0, qmag[3:0]}) : $signed({1'b0, qmag[3:0]}));
  assign prod = qs * $signed({1'b0, div_d});

  function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                    input logic [7:0] d);
    logic signed [AW:0] s;
    s = (AW+1)'(a) + (AW+1)'($signed(d));
    if (s > AMax) s = AMax;
    if (s < AMin) s = AMin;
    return s[AW-1:0];
  endfunction

  logic signed [9:0] cn, rn;
  assign cn = $signed({2'b0, col_q}) + 10'(mx_q);
  assign rn = $signed({2'b0, row_q}) - 10'(my_q);

  logic signed [16:0] wn;
  assign wn = 17'(wsum_q) + 17'($signed(cmd_i.wheel));

  logic out_free, poll_news;
  assign out_free  = !ovalid_q || !out_stall_i;
  assign poll_news = chg_q || (wsum_q != 16'sd0);

  // a poll with news loads the result register; otherwise it drains when taken
  logic load_out, ovalid_d;
  assign load_out = (st_q == mptc_pkg::ST_IDLE) && cmd_pop_o && cmd_i.poll && poll_news;
  assign ovalid_d = load_out || (ovalid_q && out_stall_i);

  always_comb begin
    st_d      = st_q;
    cmd_pop_o = 1'b0;
    case (st_q)
      mptc_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          if (cmd_i.poll) begin
            if (out_free) cmd_pop_o = 1'b1;
          end else begin
            cmd_pop_o = 1'b1;
            if (cmd_i.wheel == 8'd0) st_d = mptc_pkg::ST_ADD;
          end
        end
      end
      mptc_pkg::ST_ADD:   st_d = mptc_pkg::ST_DIV_X;
      mptc_pkg::ST_DIV_X: if (!div_go_q && !div_busy) st_d = mptc_pkg::ST_DIV_Y;
      mptc_pkg::ST_DIV_Y: if (!div_go_q && !div_busy) st_d = mptc_pkg::ST_MOVE;
      mptc_pkg::ST_MOVE:  st_d = mptc_pkg::ST_IDLE;
      default:            st_d = mptc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= mptc_pkg::ST_IDLE;
      ax_q     <= '0;
      ay_q     <= '0;
      frz_q    <= 4'd0;
      col_q    <= mptc_pkg::ColReset;
      row_q    <= mptc_pkg::RowReset;
      chg_q    <= 1'b1;
      wsum_q   <= 16'sd0;
      ovalid_q <= 1'b0;
      div_go_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      div_go_q <= (st_d == mptc_pkg::ST_DIV_X && st_q != mptc_pkg::ST_DIV_X) ||
                  (st_d == mptc_pkg::ST_DIV_Y && st_q != mptc_pkg::ST_DIV_Y);
      ovalid_q <= ovalid_d;
      case (st_q)
        mptc_pkg::ST_IDLE: begin
          if (cmd_pop_o && cmd_i.poll) begin
            if (poll_news) begin
              chg_q    <= 1'b0;
              wsum_q   <= 16'sd0;
            end
          end else if (cmd_pop_o && cmd_i.wheel != 8'd0) begin
            frz_q  <= cfg_i.freeze_len;
            ax_q   <= '0;
            ay_q   <= '0;
            chg_q  <= 1'b1;
            wsum_q <= (wn > 17'sd32767) ? 16'sh7fff :
                      (wn < -17'sd32768) ? 16'sh8000 : wn[15:0];
          end else if (cmd_pop_o) begin
            if (frz_q != 4'd0) begin
              frz_q <= frz_q - 4'd1;
              dx_q  <= 8'd0;
              dy_q  <= 8'd0;
            end else begin
              dx_q <= cmd_i.dx;
              dy_q <= cmd_i.dy;
            end
          end
        end
        mptc_pkg::ST_ADD: begin
          ax_q <= sat_add(ax_q, dx_q);
          ay_q <= sat_add(ay_q, dy_q);
        end
        mptc_pkg::ST_DIV_X, mptc_pkg::ST_DIV_Y: begin
          if (!div_go_q && !div_busy) begin
            if (cur_y) begin
              ay_q <= ay_q - AW'(prod);
              my_q <= qs;
            end else begin
              ax_q <= ax_q - AW'(prod);
              mx_q <= qs;
            end
          end
        end
        mptc_pkg::ST_MOVE: begin
          if (mx_q != 5'sd0) begin
            col_q <= (cn < 10'sd0) ? 8'd0 :
                     (cn > $signed({2'b0, cfg_i.col_limit})) ? cfg_i.col_limit : cn[7:0];
          end
          if (my_q != 5'sd0) begin
            row_q <= (rn < 10'sd0) ? 8'd0 :
                     (rn > $signed({2'b0, cfg_i.row_limit})) ? cfg_i.row_limit : rn[7:0];
          end
          if (mx_q != 5'sd0 || my_q != 5'sd0) chg_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.has_update    <= 1'b1;
      out_q.cursor_column <= col_q;
      out_q.cursor_row    <= row_q;
      out_q.wheel_total   <= wsum_q;
    end
  end
endmodule
`default_nettype wire
